[design/dbsl_pkg.sv]
// Shared constants, types and register codes for the debounced button and
// servo limit block. No dependencies.
package dbsl_pkg;

	// Sizes
	localparam int NUM_BUTTONS = 6;
	localparam int NUM_SERVOS  = 4;
	localparam int POS_WIDTH   = 15;
	localparam int COUNT_WIDTH = 8;
	localparam int STEP_WIDTH  = 12;

	localparam int BTN_W   = $clog2(NUM_BUTTONS);
	localparam int SERVO_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam int CFG_W   = (POS_WIDTH > STEP_WIDTH) ?
		((POS_WIDTH > COUNT_WIDTH) ? POS_WIDTH : COUNT_WIDTH) :
		((STEP_WIDTH > COUNT_WIDTH) ? STEP_WIDTH : COUNT_WIDTH);
	localparam int CFG_IDX_W = 3;
	// signed width for limit arithmetic, room for carry and sign
	localparam int ARITH_W = ((POS_WIDTH > STEP_WIDTH) ? POS_WIDTH : STEP_WIDTH) + 2;

	localparam logic [BTN_W-1:0] PLUS_BTN  = BTN_W'(NUM_SERVOS);
	localparam logic [BTN_W-1:0] MINUS_BTN = BTN_W'(NUM_SERVOS + 1);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [POS_WIDTH-1:0]   POS_MAX   = '1;

	// Register reset values
	localparam logic [COUNT_WIDTH-1:0] RST_DEBOUNCE = COUNT_WIDTH'(10);
	localparam logic [STEP_WIDTH-1:0]  RST_STEP     = STEP_WIDTH'(10);
	localparam logic [POS_WIDTH-1:0]   RST_ABS_MIN  = '0;
	localparam logic [POS_WIDTH-1:0]   RST_ABS_MAX  =
		(32767 > (2**POS_WIDTH - 1)) ? POS_MAX : POS_WIDTH'(32767);
	localparam logic [POS_WIDTH-1:0]   RST_INIT_LOWER =
		(1000 > (2**POS_WIDTH - 1)) ? POS_MAX : POS_WIDTH'(1000);
	localparam logic [POS_WIDTH-1:0]   RST_INIT_UPPER =
		(2000 > (2**POS_WIDTH - 1)) ? POS_MAX : POS_WIDTH'(2000);

	// Depths of the internal queues
	localparam int RUNQ_DEPTH = 2;
	localparam int RUNQ_PTR_W = $clog2(RUNQ_DEPTH);
	localparam int OUTQ_DEPTH = 2;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_STEP       = 3'd1,
		REG_ABS_MIN    = 3'd2,
		REG_ABS_MAX    = 3'd3,
		REG_INIT_LOWER = 3'd4,
		REG_INIT_UPPER = 3'd5
	} cfg_reg_t;

	// One debounced change: which buttons changed and their new levels
	typedef struct packed {
		logic [NUM_BUTTONS-1:0] change;
		logic [NUM_BUTTONS-1:0] level;
	} run_t;

	// Settings and load strobes for the servo side
	typedef struct packed {
		logic [STEP_WIDTH-1:0] adjust_step;
		logic [POS_WIDTH-1:0]  absolute_min;
		logic [POS_WIDTH-1:0]  absolute_max;
		logic                  load_lower;
		logic                  load_upper;
		logic [POS_WIDTH-1:0]  load_value;
	} servo_cfg_t;

	// One result item
	typedef struct packed {
		logic [BTN_W-1:0]     button_index;
		logic                 new_level;
		logic                 led_a_on;
		logic                 servo_touched;
		logic [SERVO_W-1:0]   servo_index;
		logic [POS_WIDTH-1:0] target_pos;
		logic [POS_WIDTH-1:0] lower_limit;
		logic [POS_WIDTH-1:0] upper_limit;
		logic                 last_of_run;
	} res_t;

endpackage

[design/dbsl_front.sv]
// Front end: stability counter and debounced pattern; emits one change
// record per accepted pattern change. Depends on dbsl_pkg.
module dbsl_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [dbsl_pkg::NUM_BUTTONS-1:0]    raw_buttons,
	input  logic [dbsl_pkg::COUNT_WIDTH-1:0]    debounce_ticks,
	input  logic                                runq_full,
	output logic                                full,
	output logic                                run_push,
	output dbsl_pkg::run_t                      run_data
);
	import dbsl_pkg::*;

	logic [NUM_BUTTONS-1:0] cand_q;
	logic [NUM_BUTTONS-1:0] deb_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_d;
	logic [NUM_BUTTONS-1:0] cand_d;
	logic                   accept;
	logic                   fire;

	assign full   = runq_full;
	assign accept = push && !runq_full;

	// Count up with saturation, restart on a new raw pattern
	always_comb begin
		cnt_d  = (cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		cand_d = cand_q;
		if (raw_buttons != cand_q) begin
			cand_d = raw_buttons;
			cnt_d  = '0;
		end
	end

	assign fire            = (deb_q != cand_d) && (cnt_d == debounce_ticks);
	assign run_push        = accept && fire;
	assign run_data.change = deb_q ^ cand_d;
	assign run_data.level  = cand_d;

	// Advance the debounce state on every accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			deb_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			cand_q <= cand_d;
			cnt_q  <= cnt_d;
			if (fire) begin
				deb_q <= cand_d;
			end
		end
	end

endmodule

[design/dbsl_runq.sv]
// Short queue of change records between front and back end.
// Depends on dbsl_pkg.
module dbsl_runq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dbsl_pkg::run_t din,
	output logic           full,
	input  logic           pop,
	output dbsl_pkg::run_t dout,
	output logic           empty
);
	import dbsl_pkg::*;

	run_t                  mem_q [RUNQ_DEPTH];
	logic [RUNQ_PTR_W-1:0] wr_q;
	logic [RUNQ_PTR_W-1:0] rd_q;
	logic [RUNQ_PTR_W:0]   cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == (RUNQ_PTR_W + 1)'(RUNQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == RUNQ_PTR_W'(RUNQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == RUNQ_PTR_W'(RUNQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/dbsl_back.sv]
// Back end: walks each record one button per cycle while its result queue
// has room, computes servo targets, updates limits. Depends on dbsl_pkg.
module dbsl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dbsl_pkg::servo_cfg_t cfg,
	input  dbsl_pkg::run_t       run_data,
	input  logic                 run_empty,
	output logic                 run_pop,
	output dbsl_pkg::res_t       res,
	output logic                 empty,
	input  logic                 pop
);
	import dbsl_pkg::*;

	// Current record
	logic [NUM_BUTTONS-1:0] rem_q;
	logic [NUM_BUTTONS-1:0] lvl_q;

	// Servo state
	logic [POS_WIDTH-1:0] lower_q  [NUM_SERVOS];
	logic [POS_WIDTH-1:0] upper_q  [NUM_SERVOS];
	logic                 last_valid_q;
	logic [SERVO_W-1:0]   last_srv_q;
	logic                 last_high_q;

	// Result queue
	res_t                  oq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] owr_q;
	logic [OUTQ_PTR_W-1:0] ord_q;
	logic [OUTQ_PTR_W:0]   ocnt_q;
	logic                  ofull;
	logic                  opop;

	logic                   busy;
	logic                   step;
	logic [BTN_W-1:0]       sel;
	logic [NUM_BUTTONS-1:0] sel_mask;
	logic                   high;
	logic                   is_servo;
	logic                   is_adj;
	logic                   wide;
	logic                   add;
	logic [SERVO_W-1:0]     srv;
	logic [POS_WIDTH-1:0]   cur_lo;
	logic [POS_WIDTH-1:0]   cur_hi;
	logic signed [ARITH_W-1:0] base;
	logic signed [ARITH_W-1:0] bound;
	logic signed [ARITH_W-1:0] sum;
	logic signed [ARITH_W-1:0] clamped;
	logic [POS_WIDTH-1:0]   new_lim;
	res_t                   res_d;

	assign busy    = (rem_q != '0);
	assign ofull   = (ocnt_q == (OUTQ_PTR_W + 1)'(OUTQ_DEPTH));
	assign empty   = (ocnt_q == '0);
	assign opop    = pop && !empty;
	assign step    = busy && !ofull;
	assign run_pop = !busy && !run_empty;
	assign res     = oq_q[ord_q];

	// Pick the lowest pending button
	always_comb begin
		sel = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				sel = BTN_W'(i);
			end
		end
	end

	assign sel_mask = NUM_BUTTONS'(1) << sel;
	assign high     = lvl_q[sel];
	assign is_servo = (sel < BTN_W'(NUM_SERVOS));
	assign is_adj   = ((sel == PLUS_BTN) || (sel == MINUS_BTN)) && !high && last_valid_q;
	assign wide     = (sel == PLUS_BTN);
	assign srv      = is_servo ? SERVO_W'(sel) : last_srv_q;
	assign cur_lo   = lower_q[srv];
	assign cur_hi   = upper_q[srv];

	// Move the limit used last: one add and one clamp compare
	always_comb begin
		add   = (wide != last_high_q);
		base  = last_high_q ? ARITH_W'(cur_lo) : ARITH_W'(cur_hi);
		if (wide) begin
			bound = last_high_q ? ARITH_W'(cfg.absolute_min) : ARITH_W'(cfg.absolute_max);
		end else begin
			bound = last_high_q ? ARITH_W'(cur_hi) : ARITH_W'(cur_lo);
		end
		sum = add ? base + ARITH_W'(cfg.adjust_step) : base - ARITH_W'(cfg.adjust_step);
		clamped = sum;
		if (add && (sum > bound)) begin
			clamped = bound;
		end else if (!add && (sum < bound)) begin
			clamped = bound;
		end
		new_lim = clamped[POS_WIDTH-1:0];
	end

	// Build the result item
	always_comb begin
		res_d               = '0;
		res_d.button_index  = sel;
		res_d.new_level     = high;
		res_d.last_of_run   = ((rem_q & ~sel_mask) == '0);
		if (is_servo) begin
			res_d.led_a_on      = !high;
			res_d.servo_touched = 1'b1;
			res_d.servo_index   = srv;
			res_d.target_pos    = high ? cur_lo : cur_hi;
			res_d.lower_limit   = cur_lo;
			res_d.upper_limit   = cur_hi;
		end else if (is_adj) begin
			res_d.servo_touched = 1'b1;
			res_d.servo_index   = srv;
			res_d.target_pos    = new_lim;
			res_d.lower_limit   = last_high_q ? new_lim : cur_lo;
			res_d.upper_limit   = last_high_q ? cur_hi : new_lim;
		end
	end

	// Load records, drop handled buttons, update servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q        <= '0;
			lvl_q        <= '0;
			last_valid_q <= 1'b0;
			last_srv_q   <= '0;
			last_high_q  <= 1'b0;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				lower_q[i] <= RST_INIT_LOWER;
				upper_q[i] <= RST_INIT_UPPER;
			end
		end else begin
			if (run_pop) begin
				rem_q <= run_data.change;
				lvl_q <= run_data.level;
			end else if (step) begin
				rem_q <= rem_q & ~sel_mask;
			end
			if (step && is_servo) begin
				last_valid_q <= 1'b1;
				last_srv_q   <= srv;
				last_high_q  <= high;
			end else if (step && is_adj) begin
				if (last_high_q) begin
					lower_q[srv] <= new_lim;
				end else begin
					upper_q[srv] <= new_lim;
				end
			end
			if (cfg.load_lower) begin
				for (int i = 0; i < NUM_SERVOS; i++) begin
					lower_q[i] <= cfg.load_value;
				end
			end
			if (cfg.load_upper) begin
				for (int i = 0; i < NUM_SERVOS; i++) begin
					upper_q[i] <= cfg.load_value;
				end
			end
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (step) begin
			oq_q[owr_q] <= res_d;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (step) begin
				owr_q <= (owr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= (ord_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_q + 1'b1;
			end
			if (step && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (!step && opop) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule

[design/debounced_button_servo_limits.sv]
// Top level: register file, front end, change queue and back end.
// Depends on dbsl_pkg, dbsl_front, dbsl_runq, dbsl_back.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     push / full        raw_buttons
//  result    empty / pop        button_index .. last_of_run
//  config    cfg_wr             cfg_idx, cfg_data
//
// A tick is taken whenever the change queue has room; a tick that
// changes the debounced pattern adds one record. The back end first
// loads a record, then handles one changed button per cycle while the
// result queue has room. Reset clears the debounce state and loads the
// servo limits at once. A full result queue stalls the back end only;
// the front keeps taking ticks until the change queue fills.
module debounced_button_servo_limits (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [dbsl_pkg::NUM_BUTTONS-1:0]     raw_buttons,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [dbsl_pkg::BTN_W-1:0]           button_index,
	output logic                                 new_level,
	output logic                                 led_a_on,
	output logic                                 servo_touched,
	output logic [dbsl_pkg::SERVO_W-1:0]         servo_index,
	output logic [dbsl_pkg::POS_WIDTH-1:0]       target_pos,
	output logic [dbsl_pkg::POS_WIDTH-1:0]       lower_limit,
	output logic [dbsl_pkg::POS_WIDTH-1:0]       upper_limit,
	output logic                                 last_of_run,
	input  logic                                 cfg_wr,
	input  logic [dbsl_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [dbsl_pkg::CFG_W-1:0]           cfg_data
);
	import dbsl_pkg::*;

	logic [COUNT_WIDTH-1:0] debounce_q;
	logic [STEP_WIDTH-1:0]  step_q;
	logic [POS_WIDTH-1:0]   abs_min_q;
	logic [POS_WIDTH-1:0]   abs_max_q;

	logic       runq_full;
	logic       runq_empty;
	logic       run_push;
	logic       run_pop;
	run_t       run_in;
	run_t       run_out;
	servo_cfg_t servo_cfg;
	res_t       res;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= RST_DEBOUNCE;
			step_q     <= RST_STEP;
			abs_min_q  <= RST_ABS_MIN;
			abs_max_q  <= RST_ABS_MAX;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_idx))
				REG_DEBOUNCE: debounce_q <= cfg_data[COUNT_WIDTH-1:0];
				REG_STEP:     step_q     <= cfg_data[STEP_WIDTH-1:0];
				REG_ABS_MIN:  abs_min_q  <= cfg_data[POS_WIDTH-1:0];
				REG_ABS_MAX:  abs_max_q  <= cfg_data[POS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Servo side settings and limit load strobes
	always_comb begin
		servo_cfg.adjust_step  = step_q;
		servo_cfg.absolute_min = abs_min_q;
		servo_cfg.absolute_max = abs_max_q;
		servo_cfg.load_lower   = cfg_wr && (cfg_reg_t'(cfg_idx) == REG_INIT_LOWER);
		servo_cfg.load_upper   = cfg_wr && (cfg_reg_t'(cfg_idx) == REG_INIT_UPPER);
		servo_cfg.load_value   = cfg_data[POS_WIDTH-1:0];
	end

	dbsl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.raw_buttons    (raw_buttons),
		.debounce_ticks (debounce_q),
		.runq_full      (runq_full),
		.full           (full),
		.run_push       (run_push),
		.run_data       (run_in)
	);

	dbsl_runq u_runq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (run_push),
		.din    (run_in),
		.full   (runq_full),
		.pop    (run_pop),
		.dout   (run_out),
		.empty  (runq_empty)
	);

	dbsl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (servo_cfg),
		.run_data  (run_out),
		.run_empty (runq_empty),
		.run_pop   (run_pop),
		.res       (res),
		.empty     (empty),
		.pop       (pop)
	);

	assign button_index  = res.button_index;
	assign new_level     = res.new_level;
	assign led_a_on      = res.led_a_on;
	assign servo_touched = res.servo_touched;
	assign servo_index   = res.servo_index;
	assign target_pos    = res.target_pos;
	assign lower_limit   = res.lower_limit;
	assign upper_limit   = res.upper_limit;
	assign last_of_run   = res.last_of_run;

endmodule
